// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the timer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mset_pkg.sv =====
// ----------------------------------------------------------------------------
// mset_pkg
// Shared constants and types of the multi-slot event timer.
// ----------------------------------------------------------------------------
`default_nettype none

package mset_pkg;

    // default configuration
    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 24;

    // request / result field widths
    localparam int FUNC_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int DELAY_W = 24;
    localparam int CODE_W  = 8;
    localparam int KIND_W  = 2;

    // slot numbers a cancel request can name
    localparam int SLOT_RANGE = 1 << SLOT_W;

    // firings reported per tick, and the counter that tracks them
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // request functions
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REG    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SOFT   = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL = 2'd2;

    // per-cell command, driven by the top level
    typedef struct packed {
        logic tick;
        logic soft_rst;
        logic grant;
        logic wr;
        logic cancel;
    } cell_cmd_t;

    // scan token passed from cell to cell
    typedef struct packed {
        logic             tok;
        logic [CNT_W-1:0] cnt;
    } link_t;

    // per-cell status seen by the top level
    typedef struct packed {
        logic              active;
        logic              due;
        logic              want;
        logic              tok;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] owner;
    } cell_stat_t;

    // one result
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] owner;
        logic              last;
    } rsp_t;

endpackage

`default_nettype wire

// ===== design/mset_ifs.sv =====
// ----------------------------------------------------------------------------
// mset_ifs
// Valid/ready channels for timer requests and timer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mset_req_if;
    logic                         valid;
    logic                         ready;
    logic [mset_pkg::FUNC_W-1:0]  func;
    logic [mset_pkg::SLOT_W-1:0]  slot;
    logic [mset_pkg::DELAY_W-1:0] delay;
    logic                         periodic;
    logic [mset_pkg::CODE_W-1:0]  event_code;
    logic [mset_pkg::CODE_W-1:0]  owner_tag;

    modport source (output valid, func, slot, delay, periodic, event_code, owner_tag,
                    input ready);
    modport sink   (input valid, func, slot, delay, periodic, event_code, owner_tag,
                    output ready);
endinterface

interface mset_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mset_pkg::KIND_W-1:0] kind;
    logic [mset_pkg::SLOT_W-1:0] fired_slot;
    logic [mset_pkg::CODE_W-1:0] fired_code;
    logic [mset_pkg::CODE_W-1:0] fired_owner;
    logic                        last;

    modport source (output valid, kind, fired_slot, fired_code, fired_owner, last,
                    input ready);
    modport sink   (input valid, kind, fired_slot, fired_code, fired_owner, last,
                    output ready);
endinterface

`default_nettype wire

// ===== design/multi_slot_event_timer.sv =====
// ----------------------------------------------------------------------------
// multi_slot_event_timer
// A row of SLOTS timer cells. Register, cancel and soft reset requests, and
// a tick with no due slot, need no scan; the next request is accepted as
// soon as a pending result has moved into the output register. A tick with
// due slots launches a scan token that walks the cell row one cell per cycle
// while the result side does not stall it; firings leave in slot order through
// a one-entry hold stage and the output register. Control state is flip-flops
// cleared by reset, with no clearing pass; result data, codes and owners carry
// no reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module multi_slot_event_timer #(
    parameter int SLOTS     = mset_pkg::SLOTS_DEF,
    parameter int TIME_BITS = mset_pkg::TIME_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mset_req_if.sink    req,
    mset_rsp_if.source  rsp
);

    mset_pkg::cell_cmd_t  cmd  [SLOTS];
    mset_pkg::cell_stat_t stat [SLOTS];
    mset_pkg::link_t      link [SLOTS+1];

    logic [SLOTS-1:0]     active_vec;
    logic [SLOTS-1:0]     free_vec;
    logic [SLOTS-1:0]     first_free;
    logic [SLOTS-1:0]     want_vec;
    logic [SLOTS-1:0]     tok_vec;
    logic [SLOTS-1:0]     due_vec;
    logic [TIME_BITS-1:0] wr_delay;

    logic                        full;
    logic                        busy;
    logic                        acc;
    logic                        acc_tick;
    logic                        acc_reg;
    logic                        acc_cancel;
    logic                        acc_soft;
    logic                        out_free;
    logic                        grant;
    logic                        any_take;
    logic                        fire_now;
    logic                        scan_end;
    logic                        h_move;
    logic [mset_pkg::CODE_W-1:0] fire_code;
    logic [mset_pkg::CODE_W-1:0] fire_owner;

    logic          h_valid_reg, h_valid_next;
    logic          h_final_reg, h_final_next;
    mset_pkg::rsp_t h_data_reg, h_data_next;
    logic          out_valid_reg, out_valid_next;
    mset_pkg::rsp_t out_data_reg;

    // one-hot to slot number, masked to the result field
    function automatic logic [mset_pkg::SLOT_W-1:0] enc_slot(input logic [SLOTS-1:0] v);
        logic [mset_pkg::SLOT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (v[i])
                idx = idx | mset_pkg::SLOT_W'(i);
        end
        return idx;
    endfunction

    // request decode
    assign out_free   = !out_valid_reg || rsp.ready;
    assign h_move     = h_valid_reg && h_final_reg && out_free;
    assign busy       = |tok_vec;
    assign req.ready  = !busy && (!h_valid_reg || h_move);
    assign acc        = req.valid && req.ready;
    assign acc_tick   = acc && (req.func == mset_pkg::FUNC_TICK);
    assign acc_reg    = acc && (req.func == mset_pkg::FUNC_REG);
    assign acc_cancel = acc && (req.func == mset_pkg::FUNC_CANCEL);
    assign acc_soft   = acc && (req.func == mset_pkg::FUNC_SOFT);
    assign wr_delay   = TIME_BITS'(req.delay);

    // lowest free slot
    assign free_vec   = ~active_vec;
    assign first_free = free_vec & (~free_vec + SLOTS'(1));
    assign full       = ~|free_vec;

    // scan control: hold stage takes a firing when it can pass its old one on
    assign grant    = !h_valid_reg || out_free;
    assign any_take = |want_vec;
    assign fire_now = any_take && grant;
    assign scan_end = link[SLOTS].tok;

    assign link[0].tok = acc_tick && (|due_vec);
    assign link[0].cnt = '0;

    // cell row
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        assign cmd[g].tick     = acc_tick;
        assign cmd[g].soft_rst = acc_soft;
        assign cmd[g].grant    = grant;
        assign cmd[g].wr       = acc_reg && first_free[g];
        assign cmd[g].cancel   = acc_cancel && (g < mset_pkg::SLOT_RANGE)
                                 && (req.slot == mset_pkg::SLOT_W'(g));

        assign active_vec[g] = stat[g].active;
        assign due_vec[g]    = stat[g].due;
        assign want_vec[g]   = stat[g].want;
        assign tok_vec[g]    = stat[g].tok;

        mset_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd[g]),
            .wr_delay    (wr_delay),
            .wr_periodic (req.periodic),
            .wr_code     (req.event_code),
            .wr_owner    (req.owner_tag),
            .link_in     (link[g]),
            .link_out    (link[g+1]),
            .stat        (stat[g])
        );
    end

    // data of the cell that holds the token and fires
    always_comb
    begin
        fire_code  = '0;
        fire_owner = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            fire_code  = fire_code  | (stat[i].code  & {mset_pkg::CODE_W{want_vec[i]}});
            fire_owner = fire_owner | (stat[i].owner & {mset_pkg::CODE_W{want_vec[i]}});
        end
    end

    // hold stage: keeps the newest result until the next one, or scan end, tells
    // whether it is the last
    always_comb
    begin
        h_valid_next = h_valid_reg;
        h_final_next = h_final_reg;
        h_data_next  = h_data_reg;
        if (acc_reg)
        begin
            h_valid_next = 1'b1;
            h_final_next = 1'b1;
            h_data_next.last = 1'b1;
            if (full)
            begin
                h_data_next.kind  = mset_pkg::KIND_FULL;
                h_data_next.slot  = '0;
                h_data_next.code  = '0;
                h_data_next.owner = '0;
            end
            else
            begin
                h_data_next.kind  = mset_pkg::KIND_ACK;
                h_data_next.slot  = enc_slot(first_free);
                h_data_next.code  = req.event_code;
                h_data_next.owner = req.owner_tag;
            end
        end
        else if (fire_now)
        begin
            h_valid_next      = 1'b1;
            h_final_next      = scan_end;
            h_data_next.kind  = mset_pkg::KIND_FIRE;
            h_data_next.slot  = enc_slot(want_vec);
            h_data_next.code  = fire_code;
            h_data_next.owner = fire_owner;
            h_data_next.last  = scan_end;
        end
        else if (h_move)
        begin
            h_valid_next = 1'b0;
            h_final_next = 1'b0;
        end
        else if (scan_end && h_valid_reg)
        begin
            h_final_next     = 1'b1;
            h_data_next.last = 1'b1;
        end
    end

    // output register
    assign out_valid_next = (h_move || (fire_now && h_valid_reg)) ? 1'b1 :
                            (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg   <= 1'b0;
            h_final_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            h_valid_reg   <= h_valid_next;
            h_final_reg   <= h_final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_data_reg <= h_data_next;
        if (h_move || (fire_now && h_valid_reg))
            out_data_reg <= h_data_reg;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_data_reg.kind;
    assign rsp.fired_slot  = out_data_reg.slot;
    assign rsp.fired_code  = out_data_reg.code;
    assign rsp.fired_owner = out_data_reg.owner;
    assign rsp.last        = out_data_reg.last;

    // checks
    `ASSERT_ALWAYS(a_one_token, clk, rst_n, $onehot0(tok_vec), "more than one scan token")
    `ASSERT_IMPLY(a_scan_not_final, clk, rst_n, busy, !(h_valid_reg && h_final_reg),
                  "hold stage closed while a scan runs")
    `ASSERT_NEXT(a_reg_result, clk, rst_n, acc_reg, h_valid_reg && h_data_reg.last,
                 "register request left no final result")

endmodule

`default_nettype wire

// ===== design/mset_cell.sv =====
// ----------------------------------------------------------------------------
// mset_cell
// One timer slot: counter, reload period, code and owner, plus one stage of
// the scan chain that reports due slots in slot order.
// ----------------------------------------------------------------------------
`default_nettype none

module mset_cell #(
    parameter int TIME_BITS = mset_pkg::TIME_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mset_pkg::cell_cmd_t         cmd,
    input  wire logic [TIME_BITS-1:0]        wr_delay,
    input  wire logic                        wr_periodic,
    input  wire logic [mset_pkg::CODE_W-1:0] wr_code,
    input  wire logic [mset_pkg::CODE_W-1:0] wr_owner,
    input  wire mset_pkg::link_t             link_in,
    output mset_pkg::link_t                  link_out,
    output mset_pkg::cell_stat_t             stat
);

    logic                        active_reg, active_next;
    logic                        pend_reg, pend_next;
    logic [TIME_BITS-1:0]        rem_reg, rem_next;
    logic [TIME_BITS-1:0]        per_reg, per_next;
    logic [mset_pkg::CODE_W-1:0] code_reg;
    logic [mset_pkg::CODE_W-1:0] owner_reg;
    logic                        tok_reg, tok_next;
    logic [mset_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic due;
    logic room;
    logic take;
    logic fire;
    logic drop;
    logic stall;

    // scan stage: report a pending slot while the tick still has room
    assign due   = active_reg && (rem_reg <= TIME_BITS'(1));
    assign room  = cnt_reg < mset_pkg::CNT_W'(mset_pkg::MAX_RESULTS);
    assign take  = tok_reg && pend_reg && room;
    assign fire  = take && cmd.grant;
    assign drop  = tok_reg && pend_reg && !room;
    assign stall = take && !cmd.grant;

    assign link_out.tok = tok_reg && !stall;
    assign link_out.cnt = cnt_reg + mset_pkg::CNT_W'(fire);

    assign tok_next = stall ? 1'b1 : link_in.tok;
    assign cnt_next = stall ? cnt_reg : link_in.cnt;

    assign stat.active = active_reg;
    assign stat.due    = due;
    assign stat.want   = take;
    assign stat.tok    = tok_reg;
    assign stat.code   = code_reg;
    assign stat.owner  = owner_reg;

    // slot state update
    always_comb
    begin
        active_next = active_reg;
        pend_next   = pend_reg;
        rem_next    = rem_reg;
        per_next    = per_reg;
        if (cmd.wr)
        begin
            active_next = 1'b1;
            pend_next   = 1'b0;
            rem_next    = wr_delay;
            per_next    = wr_periodic ? wr_delay : '0;
        end
        else if (cmd.cancel)
        begin
            active_next = 1'b0;
            pend_next   = 1'b0;
            rem_next    = '0;
            per_next    = '0;
        end
        else if (cmd.soft_rst)
        begin
            if (active_reg && (per_reg == '0))
            begin
                active_next = 1'b0;
                rem_next    = '0;
            end
        end
        else if (cmd.tick)
        begin
            // due slots wait for the scan; the rest count down
            if (due)
                pend_next = 1'b1;
            else if (active_reg)
                rem_next = rem_reg - TIME_BITS'(1);
        end
        else if (fire)
        begin
            pend_next = 1'b0;
            if (per_reg != '0)
            begin
                rem_next = per_reg;
            end
            else
            begin
                active_next = 1'b0;
                rem_next    = '0;
            end
        end
        else if (drop)
        begin
            // over the per-tick limit: keep the count, fire next tick
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            rem_reg    <= '0;
            per_reg    <= '0;
            tok_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
            rem_reg    <= rem_next;
            per_reg    <= per_next;
            tok_reg    <= tok_next;
            cnt_reg    <= cnt_next;
        end
    end

    // code and owner carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            code_reg  <= wr_code;
            owner_reg <= wr_owner;
        end
    end

endmodule

`default_nettype wire
